// ----- rtl/carm_pkg.sv -----
// Package for the Cardan angle rotation matrix block: widths and CORDIC constants.
package carm_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int CORDIC_STEPS    = 30;
  localparam int CW              = 34;  // CORDIC and product datapath width
  localparam int ZW              = 32;  // residual angle width
  localparam int NUM_OUT         = 9;
  localparam logic signed [CW-1:0] CORDIC_ONE = 34'sd652032874;

  typedef logic signed [CW-1:0] q30_t;

  // Arctangent of 2^-i, 2^32 per turn.
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 32'sh20000000;   1: r = 32'sh12E4051D;   2: r = 32'sh09FB385B;
        3: r = 32'sh051111D4;   4: r = 32'sh028B0D43;   5: r = 32'sh0145D7E1;
        6: r = 32'sh00A2F61E;   7: r = 32'sh00517C55;   8: r = 32'sh0028BE53;
        9: r = 32'sh00145F2F;  10: r = 32'sh000A2F98;  11: r = 32'sh000517CC;
        12: r = 32'sh00028BE6; 13: r = 32'sh000145F3;  14: r = 32'sh0000A2F9;
        15: r = 32'sh0000517C; 16: r = 32'sh000028BE;  17: r = 32'sh0000145F;
        18: r = 32'sh00000A2F; 19: r = 32'sh00000517;  20: r = 32'sh0000028B;
        21: r = 32'sh00000145; 22: r = 32'sh000000A2;  23: r = 32'sh00000051;
        24: r = 32'sh00000028; 25: r = 32'sh00000014;  26: r = 32'sh0000000A;
        27: r = 32'sh00000005; 28: r = 32'sh00000002;  29: r = 32'sh00000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/cardan_angle_rotation_matrix.sv -----
// Top level of the Cardan angle rotation matrix block: CORDIC sine-cosine and matrix products.
//
// Usage: s_axis carries one attitude item per beat: three binary angles
// (alpha about x, beta about y, gamma about z), 2^ANGLE_WIDTH counts a turn.
// m_axis returns one item per input: the nine rotation matrix entries in
// signed Q1.FRAC_BITS, saturated to plus or minus one.
// Throughput: one item per cycle while the output is not stalled. Depth: 35
// register stages (one angle register, 30 CORDIC step stages, a quadrant
// stage, two product stages, one output stage). The CORDIC chain sets the depth.
// The pipeline advances as a whole; when m_axis_tready is low and the output
// register is full every stage holds, so nothing is lost or repeated, and
// s_axis_tready drops only while the last stage is full and stalled.
// Reset (rst, synchronous) clears all valid bits; data registers keep junk.
module cardan_angle_rotation_matrix #(
  parameter int ANGLE_WIDTH = carm_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS   = carm_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_angle, second_angle, third_angle (lowest bits first), zero fill to bytes
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // r00, r10, r20, r01, r11, r21, r02, r12, r22 (lowest bits first), zero fill
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  import carm_pkg::*;

  localparam int OW    = FRAC_BITS + 2;
  localparam int NST   = CORDIC_STEPS;
  localparam int SH    = 30 - FRAC_BITS;
  localparam int IW    = 3 * ANGLE_WIDTH;
  localparam int OTW   = ((9*OW+7)/8)*8;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: map angles to 32-bit turn units
  logic             v0;
  logic [ZW-1:0]    ang0 [3];
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_axis_tvalid;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ang0[k] <= ZW'({s_axis_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH], 32'd0} >> ANGLE_WIDTH);
      end
    end
  end

  // CORDIC step stages, three lanes each
  logic          cv [NST+1];
  q30_t          cx [NST+1][3];
  q30_t          cy [NST+1][3];
  logic signed [ZW-1:0] cz [NST+1][3];
  logic [1:0]    cq [NST+1][3];

  always_comb begin
    cv[0] = v0;
    for (int k = 0; k < 3; k++) begin
      cx[0][k] = CORDIC_ONE;
      cy[0][k] = '0;
      cz[0][k] = ZW'({2'b00, ang0[k][29:0]});
      cq[0][k] = ang0[k][31:30];
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          cq[i+1][k] <= cq[i][k];
          if (!cz[i][k][ZW-1]) begin
            cx[i+1][k] <= cx[i][k] - (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] + (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] - atan_val(i);
          end else begin
            cx[i+1][k] <= cx[i][k] + (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] - (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] + atan_val(i);
          end
        end
      end
    end
  end

  // quadrant stage: cosine and sine per angle
  logic vq;
  q30_t cs [3];
  q30_t sn [3];
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else if (adv) vq <= cv[NST];
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        case (cq[NST][k])
          2'd0: begin cs[k] <= cx[NST][k];  sn[k] <= cy[NST][k];  end
          2'd1: begin cs[k] <= -cy[NST][k]; sn[k] <= cx[NST][k];  end
          2'd2: begin cs[k] <= -cx[NST][k]; sn[k] <= -cy[NST][k]; end
          default: begin cs[k] <= cy[NST][k]; sn[k] <= -cx[NST][k]; end
        endcase
      end
    end
  end

  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [2*CW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      return q30_t'(p >>> 30);
    end
  endfunction

  // product stage 1: two-factor terms
  logic v1;
  q30_t sasb, casb, cbcg, cbsg, sacb, cacb, casg, sasg, cacg, sacg, sb1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= vq;
    if (adv) begin
      sasb <= qmul(sn[0], sn[1]);
      casb <= qmul(cs[0], sn[1]);
      cbcg <= qmul(cs[1], cs[2]);
      cbsg <= qmul(cs[1], sn[2]);
      sacb <= qmul(sn[0], cs[1]);
      cacb <= qmul(cs[0], cs[1]);
      casg <= qmul(cs[0], sn[2]);
      sasg <= qmul(sn[0], sn[2]);
      cacg <= qmul(cs[0], cs[2]);
      sacg <= qmul(sn[0], cs[2]);
      sb1  <= sn[1];
    end
  end

  // product stage 2: three-factor terms and sums
  logic v2;
  q30_t m [NUM_OUT];
  logic signed [CW-1:0] cgr, sgr;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      m[0] <= cbcg;
      m[1] <= qmul(sasb, cgr) + casg;
      m[2] <= sasg - qmul(casb, cgr);
      m[3] <= -cbsg;
      m[4] <= cacg - qmul(sasb, sgr);
      m[5] <= qmul(casb, sgr) + sacg;
      m[6] <= sb1;
      m[7] <= -sacb;
      m[8] <= cacb;
    end
  end

  // gamma sine and cosine delayed one stage to line up with stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      cgr <= cs[2];
      sgr <= sn[2];
    end
  end

  // output stage: round, saturate, pack
  function automatic logic [OW-1:0] to_out(input q30_t v);
    q30_t r;
    begin
      r = (v + q30_t'((64'd1 << SH) >> 1)) >>> SH;
      if (r > q30_t'(64'd1 << FRAC_BITS)) r = q30_t'(64'd1 << FRAC_BITS);
      if (r < -q30_t'(64'd1 << FRAC_BITS)) r = -q30_t'(64'd1 << FRAC_BITS);
      return r[OW-1:0];
    end
  endfunction

  logic [OTW-1:0] odata_next;
  always_comb begin
    odata_next = '0;
    for (int k = 0; k < NUM_OUT; k++) odata_next[k*OW +: OW] = to_out(m[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v2;
    if (adv) m_axis_tdata <= odata_next;
  end

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, IW[0]};

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the Cardan angle rotation matrix block: stream stimulus and matrix checking.
`timescale 1ns / 100ps

module tb_top;
  import carm_pkg::*;

  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OW = FB + 2;
  localparam int IN_W = ((3 * AW + 7) / 8) * 8;
  localparam int OUT_W = ((9 * OW + 7) / 8) * 8;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [OUT_W-1:0] matrix_q[$];
  int mismatches;
  int matrices_seen;
  int angles_sent;
  int stall_cycles;
  int hold_len;
  bit quiet;

  string entry_name[9] = '{"r00", "r10", "r20", "r01", "r11", "r21", "r02", "r12", "r22"};

  longint atan_lut[30] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  cardan_angle_rotation_matrix DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Q30 product, round half up
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // CORDIC sine and cosine of a binary angle, Q30
  function automatic void angle_sin_cos(input logic [AW-1:0] ang, output longint c,
                                        output longint s);
    logic [31:0] a;
    longint x, y, z, dx, dy;
    begin
      a = {ang, {(32 - AW){1'b0}}};
      x = 652032874;
      y = 0;
      z = 0;
      z[29:0] = a[29:0];
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_lut[i];
        end else begin
          x += dx; y -= dy; z += atan_lut[i];
        end
      end
      case (a[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    end
  endfunction

  // Q30 to saturated Q1.FB
  function automatic logic [OW-1:0] q30_to_entry(input longint v);
    longint r;
    begin
      r = (v + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
      if (r > (64'sd1 <<< FB)) r = 64'sd1 <<< FB;
      if (r < -(64'sd1 <<< FB)) r = -(64'sd1 <<< FB);
      return r[OW-1:0];
    end
  endfunction

  function automatic logic [OUT_W-1:0] rotation_matrix(input logic [AW-1:0] al,
                                                       input logic [AW-1:0] be,
                                                       input logic [AW-1:0] ga);
    longint ca, sa, cb, sb, cg, sg, sasb, casb;
    longint m[9];
    logic [OUT_W-1:0] packed_m;
    begin
      angle_sin_cos(al, ca, sa);
      angle_sin_cos(be, cb, sb);
      angle_sin_cos(ga, cg, sg);
      sasb = q30_mul(sa, sb);
      casb = q30_mul(ca, sb);
      m[0] = q30_mul(cb, cg);
      m[1] = q30_mul(sasb, cg) + q30_mul(ca, sg);
      m[2] = -q30_mul(casb, cg) + q30_mul(sa, sg);
      m[3] = -q30_mul(cb, sg);
      m[4] = -q30_mul(sasb, sg) + q30_mul(ca, cg);
      m[5] = q30_mul(casb, sg) + q30_mul(sa, cg);
      m[6] = sb;
      m[7] = -q30_mul(sa, cb);
      m[8] = q30_mul(ca, cb);
      packed_m = '0;
      for (int k = 0; k < 9; k++) packed_m[k*OW +: OW] = q30_to_entry(m[k]);
      return packed_m;
    end
  endfunction

  // Offer one item, idle first at random, hold until accepted
  task automatic send_angles(input logic [AW-1:0] al, input logic [AW-1:0] be,
                             input logic [AW-1:0] ga);
    if (!quiet && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({ga, be, al});
    do @(posedge clk); while (!s_axis_tready);
    matrix_q.push_back(rotation_matrix(al, be, ga));
    angles_sent++;
  endtask

  // Receiver: long hold when asked, else random idling
  always @(posedge clk) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len--;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  // Compare each accepted matrix with the oldest prediction
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    bit bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      matrices_seen++;
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected matrix %h", m_axis_tdata);
      end else begin
        want = matrix_q.pop_front();
        bad = 0;
        for (int k = 0; k < 9; k++) begin
          if (m_axis_tdata[k*OW +: OW] !== want[k*OW +: OW]) begin
            bad = 1;
            if (mismatches < 10)
              $display("ERROR: matrix %0d %s expected %0d got %0d", matrices_seen,
                       entry_name[k], $signed(want[k*OW +: OW]),
                       $signed(m_axis_tdata[k*OW +: OW]));
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("FAIL cardan_angle_rotation_matrix");
      $finish;
    end
  end

  // Extremes, quadrant edges and wrap at half a turn
  task automatic test_directed();
    logic [AW-1:0] edges[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                16'h7FFF, 16'hFFFF, 16'h0001, 16'h2000};
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[i], edges[i]);
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    send_angles(16'h8000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h8000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h8000);
    send_angles(16'h3FFF, 16'hBFFF, 16'h4001);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_angles(AW'($urandom_range(0, 16'hFFFF)), AW'($urandom_range(0, 16'hFFFF)),
                  AW'($urandom_range(0, 16'hFFFF)));
  endtask

  // Stall the receiver long enough to fill the pipeline
  task automatic test_backpressure();
    hold_len = 200;
    test_random(100);
  endtask

  task automatic test_full_rate();
    quiet = 1;
    test_random(100);
    quiet = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    matrices_seen = 0;
    angles_sent = 0;
    stall_cycles = 0;
    hold_len = 0;
    quiet = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(450);
    test_backpressure();
    test_full_rate();
    test_random(450);
    s_axis_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d angle triples incl. quadrant edges, wrap and long output stall;",
             angles_sent);
    $display("checked %0d matrices, %0d mismatching.", matrices_seen, mismatches);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("PASS cardan_angle_rotation_matrix");
    end else begin
      $display("FAIL cardan_angle_rotation_matrix");
    end
    $finish;
  end

endmodule
